/* rtl/core/assert_macros.svh */
// Assertion macros shared by the steering mover RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SMK_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define SMK_ASSERT(label, prop, msg)
`define SMK_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

/* rtl/core/smk_pkg.sv */
// Types, codes and helpers of the steering mover kinematics block
`timescale 1ns / 1ps
package smk_pkg;

    typedef enum logic [2:0] {
        OP_UPDATE = 3'd0,
        OP_FORCE  = 3'd1,
        OP_SEEK   = 3'd2,
        OP_FLEE   = 3'd3,
        OP_ARRIVE = 3'd4,
        OP_SET    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_MAX_FORCE = 2'd1,
        CFG_MASS      = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MC_X   = 2'd0,
        MC_Y   = 2'd1,
        MC_SPD = 2'd2
    } md_comp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISP,
        ST_MAG_SQX,
        ST_MAG_SQY,
        ST_MAG_LD,
        ST_UNIT,
        ST_MAG_DONE,
        ST_LIM_CHK,
        ST_MD_MUL,
        ST_MD_WB,
        ST_UPD_FIN,
        ST_APPLY,
        ST_APPLY_FIN,
        ST_ARR_CHK,
        ST_STEER_DIR,
        ST_STEER_SUB,
        ST_OUT
    } state_t;

    localparam logic [24:0] MAX_SPEED_RST = 25'd262144;
    localparam logic [24:0] MAX_FORCE_RST = 25'd262144;
    localparam logic [24:0] MASS_RST      = 25'd65536;
    localparam logic [24:0] ONE_Q16       = 25'd65536;
    localparam logic [31:0] SLOW_RADIUS   = 32'd6553600;
    localparam logic [5:0]  SQRT_STEPS    = 6'd32;
    localparam logic [5:0]  DIV_STEPS     = 6'd56;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat57(input logic signed [56:0] v);
        if (v > 57'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -57'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        if (v[31])
            return 32'(-v);
        else
            return v;
    endfunction

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

endpackage

/* rtl/core/steering_mover_kinematics_top.sv */
// Steering mover: location, velocity and acceleration with a shared sqrt/divide unit
// Set location and unused codes skip the unit; arrive inside the slowing radius adds a divide
// for the desired speed. Each magnitude runs 32 sqrt steps, each divide 56 quotient bits,
// all through one shift-subtract unit.
// Requests are taken one at a time; in_stall is high from accept until the result loads.
// Reset: async active low; state cleared, registers back to 4.0 / 4.0 / 1.0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module steering_mover_kinematics_top
    import smk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic [30:0]        arrive_dist,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] loc_x,
    output logic signed [31:0] loc_y,
    output logic               arrived,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [24:0]        cfg_data
);

    state_t state_reg, state_next;
    state_t mag_ret_reg, mag_ret_next;
    state_t lim_ret_reg, lim_ret_next;
    state_t md_ret_reg, md_ret_next;
    md_comp_t comp_reg, comp_next;

    logic [24:0] max_speed_reg, max_force_reg, mass_reg;

    logic [2:0]         op_reg, op_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [30:0]        dist_reg, dist_next;

    logic signed [31:0] locx_reg, locx_next, locy_reg, locy_next;
    logic signed [31:0] velx_reg, velx_next, vely_reg, vely_next;
    logic signed [31:0] accx_reg, accx_next, accy_reg, accy_next;

    logic signed [31:0] wx_reg, wx_next, wy_reg, wy_next;
    logic [31:0]        mag_reg, mag_next;
    logic [24:0]        spd_reg, spd_next;
    logic [24:0]        lim_reg, lim_next;
    logic [31:0]        dv_reg, dv_next;
    logic               neg_reg, neg_next;
    logic [63:0]        sqa_reg, sqa_next, sqb_reg, sqb_next;

    logic [63:0] src_reg, src_next;
    logic [35:0] rem_reg, rem_next;
    logic [55:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;

    logic               arr_reg, arr_next;
    logic               ovalid_reg, ovalid_next;
    logic signed [31:0] olocx_reg, olocx_next, olocy_reg, olocy_next;
    logic               oarr_reg, oarr_next;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        product;
    logic signed [31:0] opnd;
    logic [35:0]        rem_sh, trial, diff;
    logic               ge;
    logic signed [31:0] dx, dy;
    logic signed [33:0] desx, desy;
    logic signed [56:0] qv;
    logic               out_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign loc_x     = olocx_reg;
    assign loc_y     = olocy_reg;
    assign arrived   = oarr_reg;
    assign out_load  = !ovalid_reg || !out_stall;

    assign dx = sat34(sx34(vx_reg) - sx34(locx_reg));
    assign dy = sat34(sx34(vy_reg) - sx34(locy_reg));

    always_comb
    begin
        unique case (comp_reg)
            MC_X:    opnd = wx_reg;
            MC_Y:    opnd = wy_reg;
            default: opnd = mag_reg;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_MAG_SQX:
            begin
                mul_a = abs32(wx_reg);
                mul_b = abs32(wx_reg);
            end
            ST_MAG_SQY:
            begin
                mul_a = abs32(wy_reg);
                mul_b = abs32(wy_reg);
            end
            default:
            begin
                mul_a = abs32(opnd);
                mul_b = {7'b0, spd_reg};
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // shared shift-subtract step: two radicand bits for sqrt, one dividend bit for divide
    assign rem_sh = sqrt_reg ? {rem_reg[33:0], src_reg[63:62]} : {rem_reg[34:0], src_reg[63]};
    assign trial  = sqrt_reg ? {2'b00, acc_reg[31:0], 2'b01} : {4'b0000, dv_reg};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    assign qv = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

    always_comb
    begin
        desx = (op_reg == OP_FLEE) ? -sx34(wx_reg) : sx34(wx_reg);
        desy = (op_reg == OP_FLEE) ? -sx34(wy_reg) : sx34(wy_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        mag_ret_next = mag_ret_reg;
        lim_ret_next = lim_ret_reg;
        md_ret_next  = md_ret_reg;
        comp_next    = comp_reg;
        op_next      = op_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        dist_next    = dist_reg;
        locx_next    = locx_reg;
        locy_next    = locy_reg;
        velx_next    = velx_reg;
        vely_next    = vely_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        wx_next      = wx_reg;
        wy_next      = wy_reg;
        mag_next     = mag_reg;
        spd_next     = spd_reg;
        lim_next     = lim_reg;
        dv_next      = dv_reg;
        neg_next     = neg_reg;
        sqa_next     = sqa_reg;
        sqb_next     = sqb_reg;
        src_next     = src_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        sqrt_next    = sqrt_reg;
        arr_next     = arr_reg;
        ovalid_next  = ovalid_reg && out_stall;
        olocx_next   = olocx_reg;
        olocy_next   = olocy_reg;
        oarr_next    = oarr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    vx_next    = vec_x;
                    vy_next    = vec_y;
                    dist_next  = arrive_dist;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                arr_next = 1'b0;
                case (op_reg)
                    OP_UPDATE:
                    begin
                        wx_next      = sat34(sx34(velx_reg) + sx34(accx_reg));
                        wy_next      = sat34(sx34(vely_reg) + sx34(accy_reg));
                        lim_next     = max_speed_reg;
                        mag_ret_next = ST_LIM_CHK;
                        lim_ret_next = ST_UPD_FIN;
                        state_next   = ST_MAG_SQX;
                    end
                    OP_FORCE:
                    begin
                        wx_next    = vx_reg;
                        wy_next    = vy_reg;
                        state_next = ST_APPLY;
                    end
                    OP_SEEK, OP_FLEE:
                    begin
                        wx_next      = dx;
                        wy_next      = dy;
                        spd_next     = max_speed_reg;
                        mag_ret_next = ST_STEER_DIR;
                        state_next   = ST_MAG_SQX;
                    end
                    OP_ARRIVE:
                    begin
                        wx_next      = dx;
                        wy_next      = dy;
                        spd_next     = max_speed_reg;
                        mag_ret_next = ST_ARR_CHK;
                        state_next   = ST_MAG_SQX;
                    end
                    OP_SET:
                    begin
                        locx_next  = vx_reg;
                        locy_next  = vy_reg;
                        state_next = ST_OUT;
                    end
                    default:
                        state_next = ST_OUT;
                endcase
            end
            ST_MAG_SQX:
            begin
                sqa_next   = product;
                state_next = ST_MAG_SQY;
            end
            ST_MAG_SQY:
            begin
                sqb_next   = product;
                state_next = ST_MAG_LD;
            end
            ST_MAG_LD:
            begin
                src_next   = sqa_reg + sqb_reg;
                rem_next   = '0;
                acc_next   = '0;
                cnt_next   = SQRT_STEPS;
                sqrt_next  = 1'b1;
                state_next = ST_UNIT;
            end
            ST_UNIT:
            begin
                rem_next = ge ? diff : rem_sh;
                acc_next = {acc_reg[54:0], ge};
                src_next = sqrt_reg ? {src_reg[61:0], 2'b00} : {src_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = sqrt_reg ? ST_MAG_DONE : ST_MD_WB;
            end
            ST_MAG_DONE:
            begin
                mag_next   = acc_reg[31:0];
                state_next = mag_ret_reg;
            end
            ST_LIM_CHK:
            begin
                if (mag_reg > {7'b0, lim_reg})
                begin
                    spd_next    = lim_reg;
                    dv_next     = mag_reg;
                    comp_next   = MC_X;
                    md_ret_next = lim_ret_reg;
                    state_next  = ST_MD_MUL;
                end
                else
                    state_next = lim_ret_reg;
            end
            ST_MD_MUL:
            begin
                src_next   = {product[55:0], 8'b0};
                rem_next   = '0;
                acc_next   = '0;
                cnt_next   = DIV_STEPS;
                sqrt_next  = 1'b0;
                neg_next   = opnd[31];
                state_next = ST_UNIT;
            end
            ST_MD_WB:
            begin
                unique case (comp_reg)
                    MC_X:
                    begin
                        wx_next    = sat57(qv);
                        comp_next  = MC_Y;
                        state_next = ST_MD_MUL;
                    end
                    MC_Y:
                    begin
                        wy_next    = sat57(qv);
                        state_next = md_ret_reg;
                    end
                    default:
                    begin
                        spd_next   = acc_reg[24:0];
                        state_next = md_ret_reg;
                    end
                endcase
            end
            ST_UPD_FIN:
            begin
                velx_next  = wx_reg;
                vely_next  = wy_reg;
                locx_next  = sat34(sx34(locx_reg) + sx34(wx_reg));
                locy_next  = sat34(sx34(locy_reg) + sx34(wy_reg));
                accx_next  = '0;
                accy_next  = '0;
                state_next = ST_OUT;
            end
            ST_APPLY:
            begin
                if (mass_reg == 25'd0)
                    state_next = ST_OUT;
                else
                begin
                    spd_next    = ONE_Q16;
                    dv_next     = {7'b0, mass_reg};
                    comp_next   = MC_X;
                    md_ret_next = ST_APPLY_FIN;
                    state_next  = ST_MD_MUL;
                end
            end
            ST_APPLY_FIN:
            begin
                accx_next  = sat34(sx34(accx_reg) + sx34(wx_reg));
                accy_next  = sat34(sx34(accy_reg) + sx34(wy_reg));
                state_next = ST_OUT;
            end
            ST_ARR_CHK:
            begin
                if (mag_reg <= {1'b0, dist_reg})
                begin
                    arr_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else if (mag_reg < SLOW_RADIUS)
                begin
                    // desired speed scales with distance inside the slowing radius
                    dv_next     = SLOW_RADIUS;
                    comp_next   = MC_SPD;
                    md_ret_next = ST_STEER_DIR;
                    state_next  = ST_MD_MUL;
                end
                else
                    state_next = ST_STEER_DIR;
            end
            ST_STEER_DIR:
            begin
                if (mag_reg != 32'd0)
                begin
                    dv_next     = mag_reg;
                    comp_next   = MC_X;
                    md_ret_next = ST_STEER_SUB;
                    state_next  = ST_MD_MUL;
                end
                else
                begin
                    wx_next    = '0;
                    wy_next    = '0;
                    state_next = ST_STEER_SUB;
                end
            end
            ST_STEER_SUB:
            begin
                wx_next      = sat34(desx - sx34(velx_reg));
                wy_next      = sat34(desy - sx34(vely_reg));
                lim_next     = max_force_reg;
                mag_ret_next = ST_LIM_CHK;
                lim_ret_next = ST_APPLY;
                state_next   = ST_MAG_SQX;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    olocx_next  = locx_reg;
                    olocy_next  = locy_reg;
                    oarr_next   = arr_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_ret_reg   <= ST_IDLE;
            lim_ret_reg   <= ST_IDLE;
            md_ret_reg    <= ST_IDLE;
            comp_reg      <= MC_X;
            max_speed_reg <= MAX_SPEED_RST;
            max_force_reg <= MAX_FORCE_RST;
            mass_reg      <= MASS_RST;
            locx_reg      <= '0;
            locy_reg      <= '0;
            velx_reg      <= '0;
            vely_reg      <= '0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            cnt_reg       <= '0;
            sqrt_reg      <= 1'b0;
            arr_reg       <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mag_ret_reg <= mag_ret_next;
            lim_ret_reg <= lim_ret_next;
            md_ret_reg  <= md_ret_next;
            comp_reg    <= comp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                    CFG_MAX_FORCE: max_force_reg <= cfg_data;
                    CFG_MASS:      mass_reg      <= cfg_data;
                    default:       ;
                endcase
            end
            locx_reg   <= locx_next;
            locy_reg   <= locy_next;
            velx_reg   <= velx_next;
            vely_reg   <= vely_next;
            accx_reg   <= accx_next;
            accy_reg   <= accy_next;
            cnt_reg    <= cnt_next;
            sqrt_reg   <= sqrt_next;
            arr_reg    <= arr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        dist_reg  <= dist_next;
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
        mag_reg   <= mag_next;
        spd_reg   <= spd_next;
        lim_reg   <= lim_next;
        dv_reg    <= dv_next;
        neg_reg   <= neg_next;
        sqa_reg   <= sqa_next;
        sqb_reg   <= sqb_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        olocx_reg <= olocx_next;
        olocy_reg <= olocy_next;
        oarr_reg  <= oarr_next;
    end

    `SMK_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_reg == ST_DISP, "request not dispatched")
    `SMK_ASSERT(a_unit_count, (state_reg == ST_UNIT) |-> (cnt_reg != 6'd0), "unit running with zero count")
    `SMK_ASSERT(a_arrived_op, (state_reg == ST_OUT && arr_reg) |-> (op_reg == OP_ARRIVE), "arrived set outside arrive")
    `SMK_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(loc_x) && $stable(arrived), "stalled result changed")

endmodule
